// File: src/pvp_pkg.sv
// pvp_pkg: shared types and constants of the perspective vertex projector.
// No dependencies.
package pvp_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MAT_00       = 3'd0;
  localparam logic [2:0] REG_MAT_01       = 3'd1;
  localparam logic [2:0] REG_MAT_10       = 3'd2;
  localparam logic [2:0] REG_MAT_11       = 3'd3;
  localparam logic [2:0] REG_DEPTH_OFFSET = 3'd4;
  localparam logic [2:0] REG_HALF_WIDTH   = 3'd5;
  localparam logic [2:0] REG_HALF_HEIGHT  = 3'd6;

  // Quotient bits: bit QW-1 flags |q| >= 2^(QW-1), i.e. saturation
  localparam int unsigned QW = 12;
  localparam logic signed [QW-1:0] OUT_MAX = 12'sd2047;
  localparam logic signed [QW-1:0] OUT_MIN = -12'sd2048;

  // Control word that rides along the divider cells
  typedef struct packed {
    logic valid;
    logic fault;
    logic col_neg;
    logic row_neg;
  } ctrl_t;

endpackage

// File: src/pvp_div_cell.sv
// pvp_div_cell: one restoring-division step for the column and row lanes.
// Depends on pvp_pkg.
module pvp_div_cell #(
  parameter int unsigned NW  = 44,
  parameter int unsigned DNW = 32,
  parameter int unsigned BIT = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  pvp_pkg::ctrl_t            ctrl_i,
  input  logic [DNW-1:0]            den_i,
  input  logic [NW-1:0]             col_rem_i,
  input  logic [NW-1:0]             row_rem_i,
  input  logic [pvp_pkg::QW-1:0]    col_quo_i,
  input  logic [pvp_pkg::QW-1:0]    row_quo_i,
  output pvp_pkg::ctrl_t            ctrl_o,
  output logic [DNW-1:0]            den_o,
  output logic [NW-1:0]             col_rem_o,
  output logic [NW-1:0]             row_rem_o,
  output logic [pvp_pkg::QW-1:0]    col_quo_o,
  output logic [pvp_pkg::QW-1:0]    row_quo_o
);

  pvp_pkg::ctrl_t           ctrl_q;
  logic [DNW-1:0]           den_q;
  logic [NW-1:0]            col_rem_q, row_rem_q, col_rem_d, row_rem_d;
  logic [pvp_pkg::QW-1:0]   col_quo_q, row_quo_q, col_quo_d, row_quo_d;
  logic [NW-1:0]            trial;

  assign trial = NW'(den_i) << BIT;

  always_comb begin
    col_rem_d = col_rem_i;
    row_rem_d = row_rem_i;
    col_quo_d = col_quo_i;
    row_quo_d = row_quo_i;
    if (col_rem_i >= trial) begin
      col_rem_d      = col_rem_i - trial;
      col_quo_d[BIT] = 1'b1;
    end
    if (row_rem_i >= trial) begin
      row_rem_d      = row_rem_i - trial;
      row_quo_d[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q     <= den_i;
      col_rem_q <= col_rem_d;
      row_rem_q <= row_rem_d;
      col_quo_q <= col_quo_d;
      row_quo_q <= row_quo_d;
    end
  end

  assign ctrl_o    = ctrl_q;
  assign den_o     = den_q;
  assign col_rem_o = col_rem_q;
  assign row_rem_o = row_rem_q;
  assign col_quo_o = col_quo_q;
  assign row_quo_o = row_quo_q;

endmodule

// File: src/perspective_vertex_projector_unit.sv
// Perspective vertex projector: rotate about y, add depth offset, divide, map to screen.
// Pipeline from input request to result: 5 arithmetic stages, 12 divider cells,
// output register. Throughput: one vertex per cycle while not stalled, one result per vertex.
// The whole pipe advances when the output register is empty or taken; stall is held
// only while a result waits. Reset clears valid bits and loads register defaults.
// Depends on pvp_pkg and pvp_div_cell.
module perspective_vertex_projector_unit #(
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  // vertex requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] x_in_i,
  input  logic signed [15:0] y_in_i,
  input  logic signed [15:0] z_in_i,
  // screen results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [11:0] screen_col_o,
  output logic signed [11:0] screen_row_o,
  output logic               depth_fault_o
);

  localparam int unsigned QW  = pvp_pkg::QW;
  // depth bound: |x*m|+|z*m| <= 2^31, offset term <= 2^(15+C)
  localparam int unsigned DW  = ((15 + COEF_FRAC_BITS) > 31 ? (15 + COEF_FRAC_BITS) : 31) + 2;
  localparam int unsigned SW  = DW + 1;   // xr+d, y'+d
  localparam int unsigned NW  = SW + 10;  // times 10-bit half
  localparam int unsigned DNW = DW - 1;   // positive depth magnitude

  // ---------------- configuration registers ----------------
  logic signed [15:0] m00_q, m01_q, m10_q, m11_q, off_q;
  logic [9:0]         hw_q, hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m00_q <= 16'sd16384;
      m01_q <= '0;
      m10_q <= '0;
      m11_q <= 16'sd16384;
      off_q <= 16'sd12288;
      hw_q  <= 10'd40;
      hh_q  <= 10'd20;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pvp_pkg::REG_MAT_00:       m00_q <= cfg_data_i;
        pvp_pkg::REG_MAT_01:       m01_q <= cfg_data_i;
        pvp_pkg::REG_MAT_10:       m10_q <= cfg_data_i;
        pvp_pkg::REG_MAT_11:       m11_q <= cfg_data_i;
        pvp_pkg::REG_DEPTH_OFFSET: off_q <= cfg_data_i;
        pvp_pkg::REG_HALF_WIDTH:   hw_q  <= cfg_data_i[9:0];
        pvp_pkg::REG_HALF_HEIGHT:  hh_q  <= cfg_data_i[9:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------- S1: four products ----------------
  logic               v1_q;
  logic signed [31:0] p00_q, p10_q, p01_q, p11_q;
  logic signed [15:0] y1_q;

  // ---------------- S2: rotated x, depth ----------------
  logic               v2_q;
  logic signed [DW-1:0] xr_q, d_q, ys_q;

  // ---------------- S3: numerators before scaling ----------------
  logic               v3_q, f3_q;
  logic signed [SW-1:0] cs_q, rs_q;
  logic [DNW-1:0]     den3_q;

  // ---------------- S4: scaled numerators ----------------
  logic               v4_q, f4_q;
  logic signed [NW-1:0] cn_q, rn_q;
  logic [DNW-1:0]     den4_q;

  // ---------------- S5: magnitudes ----------------
  pvp_pkg::ctrl_t     c5_q;
  logic [NW-1:0]      cmag_q, rmag_q;
  logic [DNW-1:0]     den5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      c5_q <= '0;
    end else if (en) begin
      v1_q          <= in_valid_i;
      v2_q          <= v1_q;
      v3_q          <= v2_q;
      v4_q          <= v3_q;
      c5_q.valid    <= v4_q;
      c5_q.fault    <= f4_q;
      c5_q.col_neg  <= cn_q[NW-1];
      c5_q.row_neg  <= rn_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p00_q  <= x_in_i * m00_q;
      p10_q  <= z_in_i * m10_q;
      p01_q  <= x_in_i * m01_q;
      p11_q  <= z_in_i * m11_q;
      y1_q   <= y_in_i;

      xr_q   <= DW'(p00_q) + DW'(p10_q);
      d_q    <= DW'(p01_q) + DW'(p11_q) + (DW'(off_q) <<< COEF_FRAC_BITS);
      ys_q   <= DW'(y1_q) <<< COEF_FRAC_BITS;

      f3_q   <= d_q[DW-1] || (d_q == '0);
      cs_q   <= SW'(xr_q) + SW'(d_q);
      rs_q   <= SW'(ys_q) + SW'(d_q);
      den3_q <= d_q[DNW-1:0];

      f4_q   <= f3_q;
      cn_q   <= NW'(cs_q) * NW'($signed({1'b0, hw_q}));
      rn_q   <= NW'(rs_q) * NW'($signed({1'b0, hh_q}));
      den4_q <= den3_q;

      cmag_q <= cn_q[NW-1] ? NW'(-cn_q) : NW'(cn_q);
      rmag_q <= rn_q[NW-1] ? NW'(-rn_q) : NW'(rn_q);
      den5_q <= den4_q;
    end
  end

  // ---------------- divider chain: one quotient bit per cell, MSB first ----------------
  pvp_pkg::ctrl_t    ch_ctrl [QW+1];
  logic [DNW-1:0]    ch_den  [QW+1];
  logic [NW-1:0]     ch_crem [QW+1];
  logic [NW-1:0]     ch_rrem [QW+1];
  logic [QW-1:0]     ch_cquo [QW+1];
  logic [QW-1:0]     ch_rquo [QW+1];

  assign ch_ctrl[0] = c5_q;
  assign ch_den[0]  = den5_q;
  assign ch_crem[0] = cmag_q;
  assign ch_rrem[0] = rmag_q;
  assign ch_cquo[0] = '0;
  assign ch_rquo[0] = '0;

  for (genvar g = 0; g < QW; g++) begin : g_cell
    pvp_div_cell #(
      .NW (NW),
      .DNW(DNW),
      .BIT(QW - 1 - g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .ctrl_i   (ch_ctrl[g]),
      .den_i    (ch_den[g]),
      .col_rem_i(ch_crem[g]),
      .row_rem_i(ch_rrem[g]),
      .col_quo_i(ch_cquo[g]),
      .row_quo_i(ch_rquo[g]),
      .ctrl_o   (ch_ctrl[g+1]),
      .den_o    (ch_den[g+1]),
      .col_rem_o(ch_crem[g+1]),
      .row_rem_o(ch_rrem[g+1]),
      .col_quo_o(ch_cquo[g+1]),
      .row_quo_o(ch_rquo[g+1])
    );
  end

  // ---------------- sign restore, saturation, output register ----------------
  pvp_pkg::ctrl_t    last;
  logic signed [QW-1:0] col_d, row_d;
  logic signed [QW-1:0] col_q, row_q;
  logic              fault_q;

  assign last = ch_ctrl[QW];

  function automatic logic signed [QW-1:0] finish(input logic neg, input logic [QW-1:0] q);
    logic signed [QW-1:0] r;
    if (q[QW-1]) r = neg ? pvp_pkg::OUT_MIN : pvp_pkg::OUT_MAX;
    else         r = neg ? -$signed(q) : $signed(q);
    return r;
  endfunction

  always_comb begin
    col_d = finish(last.col_neg, ch_cquo[QW]);
    row_d = finish(last.row_neg, ch_rquo[QW]);
    if (last.fault) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col_q   <= col_d;
      row_q   <= row_d;
      fault_q <= last.fault;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign screen_col_o  = col_q;
  assign screen_row_o  = row_q;
  assign depth_fault_o = fault_q;

  // ---------------- checks ----------------
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && depth_fault_o |-> screen_col_o == '0 && screen_row_o == '0)
    else $error("fault result with nonzero coordinates");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to held result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(screen_col_o) && $stable(screen_row_o))
    else $error("held result changed");

endmodule
